### rtl/assert_macros.svh
// assertion helpers for the rtl files, included by rmsprop_weight_update
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define RMSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define RMSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// shared widths, register codes and pipeline types of the rmsprop update
// ----------------------------------------------------------------------------
package rmsp_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int DATA_W     = 32;
    localparam int DECAY_W    = 16;
    localparam int NUM_W      = 2 * DATA_W;
    localparam int G2_W       = NUM_W - FRAC_BITS;
    localparam int T1_W       = DECAY_W + DATA_W;
    localparam int T2_W       = DECAY_W + 1 + G2_W;
    localparam int ACC_W      = T2_W + 1;
    localparam int ROOT_IN_W  = DATA_W + FRAC_BITS;
    localparam int ROOT_W     = (ROOT_IN_W + 1) / 2;
    localparam int ROOT_PAD_W = 2 * ROOT_W;
    localparam int DEN_W      = DATA_W + 1;
    localparam int DIV_SH     = DATA_W - FRAC_BITS;
    localparam int DVS_W      = DEN_W + DIV_SH;
    localparam int QUO_W      = DATA_W + 2;
    localparam int TOP_W      = NUM_W - QUO_W;
    localparam int SUM_W      = QUO_W + 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DECAY_W:0]  DECAY_ONE  = (DECAY_W+1)'(1) << DECAY_W;
    localparam logic [QUO_W-1:0]  STEP_MAX   = QUO_W'(1) << (QUO_W - 1);
    localparam logic [DATA_W-1:0] CACHE_MAX  = '1;
    localparam logic [DATA_W-1:0] WEIGHT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] WEIGHT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [DECAY_W-1:0] DECAY_RST   = 16'd64881;
    localparam logic [DATA_W-1:0]  STEP_RST    = 32'd429497;
    localparam logic [DATA_W-1:0]  EPSILON_RST = 32'd168;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY   = 2'd0,
        REG_STEP    = 2'd1,
        REG_EPSILON = 2'd2
    } reg_idx_t;

    // data that rides alongside the long root and divide pipelines
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] weight;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] cache;
        logic              clip;
    } side_t;

endpackage

### rtl/rmsp_front.sv
// ----------------------------------------------------------------------------
// rmsp_front
// gradient magnitude, products and the saturating cache update, four stages
// ----------------------------------------------------------------------------
module rmsp_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [rmsp_pkg::DATA_W-1:0]   grad,
    input  logic        [rmsp_pkg::DATA_W-1:0]   cache_in,
    input  logic signed [rmsp_pkg::DATA_W-1:0]   weight_in,
    input  logic        [rmsp_pkg::DECAY_W-1:0]  decay,
    input  logic        [rmsp_pkg::DATA_W-1:0]   step_size,
    output logic                                 out_valid,
    output rmsp_pkg::side_t                      out_side
);

    logic [3:0] vld_reg;

    logic                           neg1_reg, neg2_reg, neg3_reg;
    logic [rmsp_pkg::DATA_W-1:0]    mag1_reg;
    logic [rmsp_pkg::DATA_W-1:0]    cache1_reg, cache2_reg;
    logic [rmsp_pkg::DATA_W-1:0]    weight1_reg, weight2_reg, weight3_reg;
    logic [rmsp_pkg::NUM_W-1:0]     sq2_reg, num2_reg, num3_reg;
    logic [rmsp_pkg::T1_W-1:0]      t1_reg;
    logic [rmsp_pkg::T2_W-1:0]      t2_reg;
    rmsp_pkg::side_t                side_reg;

    logic [rmsp_pkg::DATA_W-1:0]    mag_next;
    logic [rmsp_pkg::DECAY_W:0]     keep_c;
    logic [rmsp_pkg::ACC_W-1:0]     acc_c;
    logic [rmsp_pkg::ACC_W-rmsp_pkg::DECAY_W-1:0] shr_c;
    logic                           sat_c;

    always_comb begin
        mag_next = grad[rmsp_pkg::DATA_W-1] ? (~grad + 1'b1) : grad;
        keep_c   = rmsp_pkg::DECAY_ONE - {1'b0, decay};
        acc_c    = rmsp_pkg::ACC_W'(t1_reg) + rmsp_pkg::ACC_W'(t2_reg);
        shr_c    = acc_c[rmsp_pkg::ACC_W-1:rmsp_pkg::DECAY_W];
        sat_c    = |shr_c[rmsp_pkg::ACC_W-rmsp_pkg::DECAY_W-1:rmsp_pkg::DATA_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg    <= grad[rmsp_pkg::DATA_W-1];
            mag1_reg    <= mag_next;
            cache1_reg  <= cache_in;
            weight1_reg <= weight_in;

            neg2_reg    <= neg1_reg;
            sq2_reg     <= mag1_reg * mag1_reg;
            num2_reg    <= step_size * mag1_reg;
            cache2_reg  <= cache1_reg;
            weight2_reg <= weight1_reg;

            neg3_reg    <= neg2_reg;
            t1_reg      <= decay * cache2_reg;
            t2_reg      <= keep_c * sq2_reg[rmsp_pkg::NUM_W-1:rmsp_pkg::FRAC_BITS];
            num3_reg    <= num2_reg;
            weight3_reg <= weight2_reg;

            side_reg.neg    <= neg3_reg;
            side_reg.weight <= weight3_reg;
            side_reg.num    <= num3_reg;
            side_reg.cache  <= sat_c ? rmsp_pkg::CACHE_MAX
                                     : shr_c[rmsp_pkg::DATA_W-1:0];
            side_reg.clip   <= sat_c;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_side  = side_reg;

endmodule

### rtl/rmsp_sqrt.sv
// ----------------------------------------------------------------------------
// rmsp_sqrt
// pipelined restoring square root of the new cache, one root bit per stage
// ----------------------------------------------------------------------------
module rmsp_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  rmsp_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [rmsp_pkg::ROOT_W-1:0]       out_root,
    output rmsp_pkg::side_t                   out_side
);

    localparam int N = rmsp_pkg::ROOT_W;

    logic [N-1:0]                        vld_reg;
    logic [N:0]                          rem_reg  [N];
    logic [N-1:0]                        root_reg [N];
    logic [rmsp_pkg::ROOT_PAD_W-1:0]     rad_reg  [N];
    rmsp_pkg::side_t                     side_reg [N];

    logic [rmsp_pkg::ROOT_PAD_W-1:0]     rad_first;

    assign rad_first = rmsp_pkg::ROOT_PAD_W'({in_side.cache,
                                              {rmsp_pkg::FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N:0]                      rem_prev;
        logic [N-1:0]                    root_prev;
        logic [rmsp_pkg::ROOT_PAD_W-1:0] rad_prev;
        rmsp_pkg::side_t                 side_prev;
        logic [N+2:0]                    rem_sh;
        logic [N+2:0]                    trial;
        logic                            fit;
        logic [N+2:0]                    diff;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_first;
            assign side_prev = in_side;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_prev, rad_prev[rmsp_pkg::ROOT_PAD_W-1 -: 2]};
            trial  = (N+3)'({root_prev, 2'b01});
            fit    = rem_sh >= trial;
            diff   = rem_sh - trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fit ? diff[N:0] : rem_sh[N:0];
                root_reg[k] <= {root_prev[N-2:0], fit};
                rad_reg[k]  <= {rad_prev[rmsp_pkg::ROOT_PAD_W-3:0], 2'b00};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### rtl/rmsp_div.sv
// ----------------------------------------------------------------------------
// rmsp_div
// pipelined restoring divide of the scaled step: a loading stage, then one quotient bit per stage
// ----------------------------------------------------------------------------
module rmsp_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [rmsp_pkg::DEN_W-1:0]        in_den,
    input  rmsp_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [rmsp_pkg::QUO_W-1:0]        out_quo,
    output logic                              out_ovf,
    output rmsp_pkg::side_t                   out_side
);

    localparam int N = rmsp_pkg::QUO_W;
    localparam int W = rmsp_pkg::DVS_W;

    logic [N:0]                   vld_reg;
    logic [W-1:0]                 dvs_reg  [N+1];
    logic [W-1:0]                 rem_reg  [N+1];
    logic [N-1:0]                 low_reg  [N+1];
    logic [N-1:0]                 quo_reg  [N+1];
    logic                         ovf_reg  [N+1];
    rmsp_pkg::side_t              side_reg [N+1];

    logic [W-1:0]                 dvs_next;
    logic [W-1:0]                 top_next;

    always_comb begin
        dvs_next = {in_den, {rmsp_pkg::DIV_SH{1'b0}}};
        top_next = W'(in_side.num[rmsp_pkg::NUM_W-1:N]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-1:0], in_valid};
        end
    end

    // quotient beyond its field: the step clamps anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            dvs_reg[0]  <= dvs_next;
            rem_reg[0]  <= top_next;
            low_reg[0]  <= in_side.num[N-1:0];
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= top_next >= dvs_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic [W:0] rem_sh;
        logic       fit;
        logic [W:0] diff;

        always_comb begin
            rem_sh = {rem_reg[k-1], low_reg[k-1][N-1]};
            fit    = rem_sh >= {1'b0, dvs_reg[k-1]};
            diff   = rem_sh - {1'b0, dvs_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvs_reg[k]  <= dvs_reg[k-1];
                rem_reg[k]  <= fit ? diff[W-1:0] : rem_sh[W-1:0];
                low_reg[k]  <= {low_reg[k-1][N-2:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][N-2:0], fit};
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = quo_reg[N];
    assign out_ovf   = ovf_reg[N];
    assign out_side  = side_reg[N];

endmodule

### rtl/rmsprop_weight_update.sv
// ----------------------------------------------------------------------------
// rmsprop_weight_update
// fixed-point rmsprop step for one weight element per request
// ----------------------------------------------------------------------------
// One request carries a gradient, its squared-gradient cache and its weight,
// all with 24 fraction bits; the response carries the new cache
// decay*cache + (1-decay)*g^2, the new weight w + lr*g/(sqrt(cache)+eps) and
// a flag set when either result saturated. While no response waits on
// m_ready, the block takes one request per clock and returns one response
// per clock. The pipeline has 69 register stages: products and cache
// update, a bit-per-stage square root, the denominator, a loading stage and
// bit-per-stage divide, and the output register. The first stage loads at
// the accepting edge, and the response passes through every stage in order
// to m_valid. The whole pipeline holds while a response waits on m_ready,
// so s_ready follows m_ready whenever a response is pending. Configuration
// writes (decay, step_size, epsilon) take effect at once and must be made
// while no request is in flight.
module rmsprop_weight_update (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [rmsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rmsp_pkg::DATA_W-1:0]           cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rmsp_pkg::DATA_W-1:0]    s_grad,
    input  logic        [rmsp_pkg::DATA_W-1:0]    s_cache_in,
    input  logic signed [rmsp_pkg::DATA_W-1:0]    s_weight_in,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [rmsp_pkg::DATA_W-1:0]    m_cache_out,
    output logic signed [rmsp_pkg::DATA_W-1:0]    m_weight_out,
    output logic                                  m_clipped
);

    `include "assert_macros.svh"

    // configuration registers
    logic [rmsp_pkg::DECAY_W-1:0]  decay_reg;
    logic [rmsp_pkg::DATA_W-1:0]   step_reg;
    logic [rmsp_pkg::DATA_W-1:0]   eps_reg;

    // single stall for every stage: hold all while the response is not taken
    logic en;

    logic                          fr_valid;
    rmsp_pkg::side_t               fr_side;
    logic                          sq_valid;
    logic [rmsp_pkg::ROOT_W-1:0]   sq_root;
    rmsp_pkg::side_t               sq_side;

    // denominator stage
    logic                          den_valid_reg;
    logic [rmsp_pkg::DEN_W-1:0]    den_reg;
    rmsp_pkg::side_t               den_side_reg;
    logic [rmsp_pkg::DEN_W-1:0]    den_next;

    logic                          dv_valid;
    logic [rmsp_pkg::QUO_W-1:0]    dv_quo;
    logic                          dv_ovf;
    rmsp_pkg::side_t               dv_side;

    // output stage
    logic                          m_valid_reg;
    logic [rmsp_pkg::DATA_W-1:0]   cache_out_reg;
    logic [rmsp_pkg::DATA_W-1:0]   weight_out_reg;
    logic                          clipped_reg;

    logic [rmsp_pkg::QUO_W-1:0]    step_c;
    logic [rmsp_pkg::SUM_W-1:0]    wsum_c;
    logic                          wsat_c;
    logic [rmsp_pkg::DATA_W-1:0]   weight_next;

    // response sits at a cache or weight limit
    logic                          out_at_limit;

    assign en      = !(m_valid_reg && !m_ready);
    assign s_ready = en;

    // register writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= rmsp_pkg::DECAY_RST;
            step_reg  <= rmsp_pkg::STEP_RST;
            eps_reg   <= rmsp_pkg::EPSILON_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rmsp_pkg::REG_DECAY:   decay_reg <= cfg_data[rmsp_pkg::DECAY_W-1:0];
                rmsp_pkg::REG_STEP:    step_reg  <= cfg_data;
                rmsp_pkg::REG_EPSILON: eps_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // products and saturating cache update
    rmsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .grad      (s_grad),
        .cache_in  (s_cache_in),
        .weight_in (s_weight_in),
        .decay     (decay_reg),
        .step_size (step_reg),
        .out_valid (fr_valid),
        .out_side  (fr_side)
    );

    // floor square root of the new cache in the same format
    rmsp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // root plus epsilon; a zero denominator becomes one
    always_comb begin
        den_next = rmsp_pkg::DEN_W'(sq_root) + rmsp_pkg::DEN_W'(eps_reg);
        if (den_next == '0) begin
            den_next = rmsp_pkg::DEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            den_valid_reg <= 1'b0;
        end else if (en) begin
            den_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg      <= den_next;
            den_side_reg <= sq_side;
        end
    end

    // lr*|g| over the scaled denominator, truncated
    rmsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (den_valid_reg),
        .in_den    (den_reg),
        .in_side   (den_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side)
    );

    // clamp the step, apply it with the gradient's sign, saturate the weight
    always_comb begin
        step_c = (dv_ovf || dv_quo > rmsp_pkg::STEP_MAX) ? rmsp_pkg::STEP_MAX : dv_quo;
        if (dv_side.neg) begin
            wsum_c = {{(rmsp_pkg::SUM_W-rmsp_pkg::DATA_W){dv_side.weight[rmsp_pkg::DATA_W-1]}},
                      dv_side.weight} - rmsp_pkg::SUM_W'(step_c);
        end else begin
            wsum_c = {{(rmsp_pkg::SUM_W-rmsp_pkg::DATA_W){dv_side.weight[rmsp_pkg::DATA_W-1]}},
                      dv_side.weight} + rmsp_pkg::SUM_W'(step_c);
        end
        wsat_c = !((&wsum_c[rmsp_pkg::SUM_W-1:rmsp_pkg::DATA_W-1])
                   || !(|wsum_c[rmsp_pkg::SUM_W-1:rmsp_pkg::DATA_W-1]));
        if (!wsat_c) begin
            weight_next = wsum_c[rmsp_pkg::DATA_W-1:0];
        end else if (wsum_c[rmsp_pkg::SUM_W-1]) begin
            weight_next = rmsp_pkg::WEIGHT_MIN;
        end else begin
            weight_next = rmsp_pkg::WEIGHT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cache_out_reg  <= dv_side.cache;
            weight_out_reg <= weight_next;
            clipped_reg    <= dv_side.clip || wsat_c;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cache_out  = cache_out_reg;
    assign m_weight_out = weight_out_reg;
    assign m_clipped    = clipped_reg;

    assign out_at_limit = (m_cache_out == rmsp_pkg::CACHE_MAX)
                          || (m_weight_out == rmsp_pkg::WEIGHT_MAX)
                          || (m_weight_out == rmsp_pkg::WEIGHT_MIN);

    // a clipped response always sits at one of its limits
    `RMSP_ASSERT(a_clip_at_limit, m_valid && m_clipped |-> out_at_limit, "clipped response not at a limit")
    // a pending response blocks new requests
    `RMSP_ASSERT(a_stall_blocks_input, m_valid && !m_ready |-> !s_ready, "request taken while response stalled")
    // reset empties the pipeline
    `RMSP_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "response valid after reset")

endmodule
